FILE: rtl/mid_pkg.sv
// ----------------------------------------------------------------------------
// mid_pkg
// Shared types and codes for the MIPS instruction decoder: mnemonic numbers,
// operand-format numbers and the decode result bundle.
// ----------------------------------------------------------------------------
package mid_pkg;

	localparam int MNEM_W = 7;
	localparam int FMT_W  = 4;
	localparam int WORD_W = 32;
	localparam int REG_W  = 5;
	localparam int IMM_W  = 16;
	localparam int JT_W   = 28;

	typedef enum logic [MNEM_W-1:0] {
		MN_UNKNOWN, MN_NOP,
		MN_SLL, MN_SRL, MN_SRA, MN_SLLV, MN_SRLV, MN_SRAV, MN_JR, MN_JALR,
		MN_MOVZ, MN_MOVN, MN_SYSCALL, MN_BREAK, MN_SYNC, MN_MFHI, MN_MTHI,
		MN_MFLO, MN_MTLO, MN_MULT, MN_MULTU, MN_DIV, MN_DIVU, MN_ADD, MN_ADDU,
		MN_SUB, MN_SUBU, MN_AND, MN_OR, MN_XOR, MN_NOR, MN_SLT, MN_SLTU,
		MN_BLTZ, MN_BGEZ, MN_BLTZL, MN_BGEZL,
		MN_J, MN_JAL, MN_BEQ, MN_BNE, MN_BLEZ, MN_BGTZ, MN_ADDI, MN_ADDIU,
		MN_SLTI, MN_SLTIU, MN_ANDI, MN_ORI, MN_XORI, MN_LUI, MN_BEQL, MN_BNEL,
		MN_BLEZL, MN_BGTZL, MN_LB, MN_LH, MN_LWL, MN_LW, MN_LBU, MN_LHU,
		MN_LWR, MN_LWU, MN_SB, MN_SH, MN_SWL, MN_SW, MN_SWR
	} mnem_t;

	typedef enum logic [FMT_W-1:0] {
		FMT_NONE, FMT_RS, FMT_RS_RT, FMT_RS_RD, FMT_RD_RT_RS, FMT_RD,
		FMT_SHIFT, FMT_RT_RS_IMM, FMT_RS_IMM, FMT_RT_IMM, FMT_RT_IMM_RS,
		FMT_JUMP
	} fmt_t;

	typedef struct packed {
		mnem_t mnemonic;
		fmt_t  fmt;
	} dec_t;

endpackage

FILE: rtl/mid_decode.sv
// ----------------------------------------------------------------------------
// mid_decode
// Opcode, function and REGIMM decode of one instruction word into a mnemonic
// number and an operand-format number.
// ----------------------------------------------------------------------------
module mid_decode (
	input  logic [mid_pkg::WORD_W-1:0] word,
	output mid_pkg::dec_t              dec
);
	import mid_pkg::*;

	localparam logic [5:0] OP_SPECIAL = 6'd0;
	localparam logic [5:0] OP_REGIMM  = 6'd1;
	localparam logic [5:0] OP_J     = 6'd2,  OP_JAL   = 6'd3,  OP_BEQ   = 6'd4;
	localparam logic [5:0] OP_BNE   = 6'd5,  OP_BLEZ  = 6'd6,  OP_BGTZ  = 6'd7;
	localparam logic [5:0] OP_ADDI  = 6'd8,  OP_ADDIU = 6'd9,  OP_SLTI  = 6'd10;
	localparam logic [5:0] OP_SLTIU = 6'd11, OP_ANDI  = 6'd12, OP_ORI   = 6'd13;
	localparam logic [5:0] OP_XORI  = 6'd14, OP_LUI   = 6'd15, OP_BEQL  = 6'd20;
	localparam logic [5:0] OP_BNEL  = 6'd21, OP_BLEZL = 6'd22, OP_BGTZL = 6'd23;
	localparam logic [5:0] OP_LB    = 6'd32, OP_LH    = 6'd33, OP_LWL   = 6'd34;
	localparam logic [5:0] OP_LW    = 6'd35, OP_LBU   = 6'd36, OP_LHU   = 6'd37;
	localparam logic [5:0] OP_LWR   = 6'd38, OP_LWU   = 6'd39, OP_SB    = 6'd40;
	localparam logic [5:0] OP_SH    = 6'd41, OP_SWL   = 6'd42, OP_SW    = 6'd43;
	localparam logic [5:0] OP_SWR   = 6'd46;

	localparam logic [5:0] FN_SLL   = 6'd0,  FN_SRL   = 6'd2,  FN_SRA   = 6'd3;
	localparam logic [5:0] FN_SLLV  = 6'd4,  FN_SRLV  = 6'd6,  FN_SRAV  = 6'd7;
	localparam logic [5:0] FN_JR    = 6'd8,  FN_JALR  = 6'd9,  FN_MOVZ  = 6'd10;
	localparam logic [5:0] FN_MOVN  = 6'd11, FN_SYSC  = 6'd12, FN_BRK   = 6'd13;
	localparam logic [5:0] FN_SYNC  = 6'd15, FN_MFHI  = 6'd16, FN_MTHI  = 6'd17;
	localparam logic [5:0] FN_MFLO  = 6'd18, FN_MTLO  = 6'd19, FN_MULT  = 6'd24;
	localparam logic [5:0] FN_MULTU = 6'd25, FN_DIV   = 6'd26, FN_DIVU  = 6'd27;
	localparam logic [5:0] FN_ADD   = 6'd32, FN_ADDU  = 6'd33, FN_SUB   = 6'd34;
	localparam logic [5:0] FN_SUBU  = 6'd35, FN_AND   = 6'd36, FN_OR    = 6'd37;
	localparam logic [5:0] FN_XOR   = 6'd38, FN_NOR   = 6'd39, FN_SLT   = 6'd42;
	localparam logic [5:0] FN_SLTU  = 6'd43;

	localparam logic [4:0] RT_BLTZ = 5'd0, RT_BGEZ = 5'd1;
	localparam logic [4:0] RT_BLTZL = 5'd2, RT_BGEZL = 5'd3;

	logic [5:0] op;
	logic [5:0] fn;
	logic [4:0] rt;
	dec_t       spec;
	dec_t       regimm;
	dec_t       prim;

	assign op = word[31:26];
	assign fn = word[5:0];
	assign rt = word[20:16];

	always_comb begin
		unique case (fn)
			FN_SLL:   spec = '{MN_SLL,     FMT_SHIFT};
			FN_SRL:   spec = '{MN_SRL,     FMT_SHIFT};
			FN_SRA:   spec = '{MN_SRA,     FMT_SHIFT};
			FN_SLLV:  spec = '{MN_SLLV,    FMT_RD_RT_RS};
			FN_SRLV:  spec = '{MN_SRLV,    FMT_RD_RT_RS};
			FN_SRAV:  spec = '{MN_SRAV,    FMT_RD_RT_RS};
			FN_JR:    spec = '{MN_JR,      FMT_RS};
			FN_JALR:  spec = '{MN_JALR,    FMT_RS_RD};
			FN_MOVZ:  spec = '{MN_MOVZ,    FMT_RD_RT_RS};
			FN_MOVN:  spec = '{MN_MOVN,    FMT_RD_RT_RS};
			FN_SYSC:  spec = '{MN_SYSCALL, FMT_NONE};
			FN_BRK:   spec = '{MN_BREAK,   FMT_NONE};
			FN_SYNC:  spec = '{MN_SYNC,    FMT_NONE};
			FN_MFHI:  spec = '{MN_MFHI,    FMT_RD};
			FN_MTHI:  spec = '{MN_MTHI,    FMT_RS};
			FN_MFLO:  spec = '{MN_MFLO,    FMT_RD};
			FN_MTLO:  spec = '{MN_MTLO,    FMT_RS};
			FN_MULT:  spec = '{MN_MULT,    FMT_RS_RT};
			FN_MULTU: spec = '{MN_MULTU,   FMT_RS_RT};
			FN_DIV:   spec = '{MN_DIV,     FMT_RS_RT};
			FN_DIVU:  spec = '{MN_DIVU,    FMT_RS_RT};
			FN_ADD:   spec = '{MN_ADD,     FMT_RD_RT_RS};
			FN_ADDU:  spec = '{MN_ADDU,    FMT_RD_RT_RS};
			FN_SUB:   spec = '{MN_SUB,     FMT_RD_RT_RS};
			FN_SUBU:  spec = '{MN_SUBU,    FMT_RD_RT_RS};
			FN_AND:   spec = '{MN_AND,     FMT_RD_RT_RS};
			FN_OR:    spec = '{MN_OR,      FMT_RD_RT_RS};
			FN_XOR:   spec = '{MN_XOR,     FMT_RD_RT_RS};
			FN_NOR:   spec = '{MN_NOR,     FMT_RD_RT_RS};
			FN_SLT:   spec = '{MN_SLT,     FMT_RD_RT_RS};
			FN_SLTU:  spec = '{MN_SLTU,    FMT_RD_RT_RS};
			default:  spec = '{MN_UNKNOWN, FMT_NONE};
		endcase
	end

	always_comb begin
		unique case (rt)
			RT_BLTZ:  regimm = '{MN_BLTZ,    FMT_RS_IMM};
			RT_BGEZ:  regimm = '{MN_BGEZ,    FMT_RS_IMM};
			RT_BLTZL: regimm = '{MN_BLTZL,   FMT_RS_IMM};
			RT_BGEZL: regimm = '{MN_BGEZL,   FMT_RS_IMM};
			default:  regimm = '{MN_UNKNOWN, FMT_NONE};
		endcase
	end

	always_comb begin
		unique case (op)
			OP_J:     prim = '{MN_J,       FMT_JUMP};
			OP_JAL:   prim = '{MN_JAL,     FMT_JUMP};
			OP_BEQ:   prim = '{MN_BEQ,     FMT_RT_RS_IMM};
			OP_BNE:   prim = '{MN_BNE,     FMT_RT_RS_IMM};
			OP_BLEZ:  prim = '{MN_BLEZ,    FMT_RS_IMM};
			OP_BGTZ:  prim = '{MN_BGTZ,    FMT_RS_IMM};
			OP_ADDI:  prim = '{MN_ADDI,    FMT_RT_RS_IMM};
			OP_ADDIU: prim = '{MN_ADDIU,   FMT_RT_RS_IMM};
			OP_SLTI:  prim = '{MN_SLTI,    FMT_RT_RS_IMM};
			OP_SLTIU: prim = '{MN_SLTIU,   FMT_RT_RS_IMM};
			OP_ANDI:  prim = '{MN_ANDI,    FMT_RT_RS_IMM};
			OP_ORI:   prim = '{MN_ORI,     FMT_RT_RS_IMM};
			OP_XORI:  prim = '{MN_XORI,    FMT_RT_RS_IMM};
			OP_LUI:   prim = '{MN_LUI,     FMT_RT_IMM};
			OP_BEQL:  prim = '{MN_BEQL,    FMT_RT_RS_IMM};
			OP_BNEL:  prim = '{MN_BNEL,    FMT_RT_RS_IMM};
			OP_BLEZL: prim = '{MN_BLEZL,   FMT_RS_IMM};
			OP_BGTZL: prim = '{MN_BGTZL,   FMT_RS_IMM};
			OP_LB:    prim = '{MN_LB,      FMT_RT_IMM_RS};
			OP_LH:    prim = '{MN_LH,      FMT_RT_IMM_RS};
			OP_LWL:   prim = '{MN_LWL,     FMT_RT_IMM_RS};
			OP_LW:    prim = '{MN_LW,      FMT_RT_IMM_RS};
			OP_LBU:   prim = '{MN_LBU,     FMT_RT_IMM_RS};
			OP_LHU:   prim = '{MN_LHU,     FMT_RT_IMM_RS};
			OP_LWR:   prim = '{MN_LWR,     FMT_RT_IMM_RS};
			OP_LWU:   prim = '{MN_LWU,     FMT_RT_IMM_RS};
			OP_SB:    prim = '{MN_SB,      FMT_RT_IMM_RS};
			OP_SH:    prim = '{MN_SH,      FMT_RT_IMM_RS};
			OP_SWL:   prim = '{MN_SWL,     FMT_RT_IMM_RS};
			OP_SW:    prim = '{MN_SW,      FMT_RT_IMM_RS};
			OP_SWR:   prim = '{MN_SWR,     FMT_RT_IMM_RS};
			default:  prim = '{MN_UNKNOWN, FMT_NONE};
		endcase
	end

	always_comb begin
		priority if (word == '0) begin
			dec = '{MN_NOP, FMT_NONE};
		end else if (op == OP_SPECIAL) begin
			dec = spec;
		end else if (op == OP_REGIMM) begin
			dec = regimm;
		end else begin
			dec = prim;
		end
	end

endmodule

FILE: rtl/mips_instruction_decoder_unit.sv
// ----------------------------------------------------------------------------
// mips_instruction_decoder_unit
// MIPS32 instruction decoder: mnemonic and operand-format numbers plus the
// raw register, shift, immediate and jump-target fields of each word.
// ----------------------------------------------------------------------------
// channel   signals                         handshake
// input     instruction_word                start & !busy
// result    mnemonic .. jump_target         done, one cycle, no stall
//
// one transaction per cycle; after acceptance the result passes through
// the input register, decode and the result register
// busy is always low: every stage advances each cycle
// arst_n clears the stage valid bits only; the receiver cannot stall
// ----------------------------------------------------------------------------
module mips_instruction_decoder_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [mid_pkg::WORD_W-1:0]  instruction_word,
	output logic                        done,
	output logic [mid_pkg::MNEM_W-1:0]  mnemonic,
	output logic [mid_pkg::FMT_W-1:0]   operand_format,
	output logic [mid_pkg::REG_W-1:0]   source_reg,
	output logic [mid_pkg::REG_W-1:0]   target_reg,
	output logic [mid_pkg::REG_W-1:0]   dest_reg,
	output logic [mid_pkg::REG_W-1:0]   shift_amount,
	output logic [mid_pkg::IMM_W-1:0]   immediate,
	output logic [mid_pkg::JT_W-1:0]    jump_target
);
	import mid_pkg::*;

	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	dec_t              dec;

	logic              valid_s2;
	dec_t              dec_s2;
	logic [REG_W-1:0]  rs_s2;
	logic [REG_W-1:0]  rt_s2;
	logic [REG_W-1:0]  rd_s2;
	logic [REG_W-1:0]  sa_s2;
	logic [IMM_W-1:0]  imm_s2;
	logic [JT_W-1:0]   jt_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			word_s1 <= instruction_word;
		end
	end

	mid_decode u_decode (
		.word (word_s1),
		.dec  (dec)
	);

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			dec_s2 <= dec;
			rs_s2  <= word_s1[25:21];
			rt_s2  <= word_s1[20:16];
			rd_s2  <= word_s1[15:11];
			sa_s2  <= word_s1[10:6];
			imm_s2 <= word_s1[15:0];
			jt_s2  <= {word_s1[25:0], 2'b00};
		end
	end

	assign done           = valid_s2;
	assign mnemonic       = dec_s2.mnemonic;
	assign operand_format = dec_s2.fmt;
	assign source_reg     = rs_s2;
	assign target_reg     = rt_s2;
	assign dest_reg       = rd_s2;
	assign shift_amount   = sa_s2;
	assign immediate      = imm_s2;
	assign jump_target    = jt_s2;

endmodule

FILE: rtl/mid_checker.sv
// ----------------------------------------------------------------------------
// mid_checker
// Port-level checks for the MIPS instruction decoder, bound to the top level.
// ----------------------------------------------------------------------------
module mid_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic [mid_pkg::WORD_W-1:0]  instruction_word,
	input logic                        done,
	input logic [mid_pkg::MNEM_W-1:0]  mnemonic,
	input logic [mid_pkg::FMT_W-1:0]   operand_format,
	input logic [mid_pkg::JT_W-1:0]    jump_target
);
	import mid_pkg::*;

	// every accepted transaction comes out with done raised
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted transaction produced no result");

	a_nop: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && instruction_word == '0) |->
		##2 (mnemonic == MN_NOP && operand_format == FMT_NONE))
		else $error("zero word did not decode as nop");

	a_mnem_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (mnemonic <= MN_SWR && operand_format <= FMT_JUMP))
		else $error("mnemonic or format out of range");

	a_unknown_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		(done && mnemonic == MN_UNKNOWN) |-> operand_format == FMT_NONE)
		else $error("unknown mnemonic with an operand format");

	a_jt_align: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> jump_target[1:0] == 2'b00)
		else $error("jump target not word aligned");

endmodule

bind mips_instruction_decoder_unit mid_checker u_mid_checker (.*);
